### src/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and constants for the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int PAGES_DEF  = 4096;
  localparam int WORD_W     = 32;
  localparam int BIT_W      = 5;
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 24;
  localparam int LIMIT_W    = 13;
  localparam int CNT_W      = 21;
  localparam int FIRST_W    = 20;
  localparam int SUM_W      = 22;

  localparam logic [1:0] ACT_FREE    = 2'd0;
  localparam logic [1:0] ACT_RESERVE = 2'd1;
  localparam logic [1:0] ACT_ALLOC   = 2'd2;

  typedef struct packed {
    logic [1:0]       op;
    logic             lo_en;
    logic [BIT_W-1:0] lo;
    logic             hi_en;
    logic [BIT_W-1:0] hi;
  } unit_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] word_new;
    logic              found;
    logic [BIT_W-1:0]  pos;
  } unit_res_t;

endpackage

### src/pba_map_ram.sv
// ----------------------------------------------------------------------------
// pba_map_ram
// Single write, single read bitmap store with registered read data.
// ----------------------------------------------------------------------------
module pba_map_ram import pba_pkg::*; #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = WORD_W
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### src/pba_word_unit.sv
// ----------------------------------------------------------------------------
// pba_word_unit
// Shared word unit: range masking, set/clear and lowest-free-bit search.
// ----------------------------------------------------------------------------
module pba_word_unit import pba_pkg::*; (
  input  logic [WORD_W-1:0] word,
  input  unit_req_t         req,
  output unit_res_t         res
);

  logic [WORD_W-1:0] lo_mask;
  logic [WORD_W-1:0] hi_mask;
  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] free_bits;
  logic [WORD_W-1:0] lowest;
  logic [BIT_W-1:0]  pos;

  always_comb begin
    lo_mask   = req.lo_en ? ({WORD_W{1'b1}} << req.lo) : {WORD_W{1'b1}};
    hi_mask   = req.hi_en ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - req.hi))
                          : {WORD_W{1'b1}};
    mask      = lo_mask & hi_mask;
    free_bits = ~word & mask;
    lowest    = free_bits & (~free_bits + WORD_W'(1));
    pos       = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (lowest[i]) begin
        pos = pos | BIT_W'(i);
      end
    end
  end

  always_comb begin
    res.found = |free_bits;
    res.pos   = pos;
    case (req.op)
      ACT_FREE:    res.word_new = word & ~mask;
      ACT_RESERVE: res.word_new = word | mask;
      ACT_ALLOC:   res.word_new = word | lowest;
      default:     res.word_new = word;
    endcase
  end

endmodule

### src/page_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// Bitmap physical page allocator, one used/free bit per 4 KiB page.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries action, base_address and
// range_pages; output channel (out_valid/out_ready) returns one transaction
// per input with page_address and status. cfg_wr_en/cfg_wr_data write
// alloc_limit at once; the user must write it only while the block is idle, as
// the block itself does not enforce it. The map lives in a 32-bit-wide RAM;
// each word is read (S_RD), then modified and written back (S_MOD) through
// the shared word unit. A range action visits the words it touches, an
// allocate scans words up to the first free page below alloc_limit. Empty
// ranges, zero limits and unused actions finish without touching the map.
// After reset the map is swept to all-used, one word a cycle, over every
// word of the map; in_ready stays low meanwhile.
// A finished result waits in the output register; a new transaction may be
// accepted while it waits, but the next result holds until it is taken.
// ----------------------------------------------------------------------------
module page_bitmap_allocator import pba_pkg::*; #(
  parameter int PAGES = PAGES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [LIMIT_W-1:0]  cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          action,
  input  logic [31:0]         base_address,
  input  logic [CNT_W-1:0]    range_pages,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ADDR_W-1:0]   page_address,
  output logic                status
);

  localparam int WORDS = (PAGES + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [SUM_W-1:0] PAGES_V   = SUM_W'(PAGES);
  localparam logic [AW-1:0]    LAST_WORD = AW'(WORDS - 1);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]         state;
  logic [LIMIT_W-1:0] alloc_limit;
  logic [1:0]         op;
  logic [AW-1:0]      widx;
  logic [AW-1:0]      wlast;
  logic [BIT_W-1:0]   lo;
  logic [BIT_W-1:0]   hi;
  logic               first_iter;
  logic [ADDR_W-1:0]  res_addr;
  logic               res_status;

  logic [FIRST_W-1:0] first;
  logic [SUM_W-1:0]   range_end;
  logic [SUM_W-1:0]   end_c;
  logic [SUM_W-1:0]   last_pg;
  logic [SUM_W-1:0]   lim_c;
  logic [SUM_W-1:0]   lim_m1;
  logic               last_word;
  logic [AW+BIT_W-1:0] found_pg;

  logic              ram_we;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  unit_req_t         ureq;
  unit_res_t         ures;

  assign in_ready  = (state == S_IDLE);
  assign last_word = (widx == wlast);

  always_comb begin
    first     = base_address[31:PAGE_SHIFT];
    range_end = SUM_W'(first) + SUM_W'(range_pages);
    end_c     = (range_end > PAGES_V) ? PAGES_V : range_end;
    last_pg   = end_c - SUM_W'(1);
    lim_c     = (SUM_W'(alloc_limit) > PAGES_V) ? PAGES_V : SUM_W'(alloc_limit);
    lim_m1    = lim_c - SUM_W'(1);
    found_pg  = {widx, ures.pos};
  end

  always_comb begin
    ureq.op    = op;
    ureq.lo_en = first_iter;
    ureq.lo    = lo;
    ureq.hi_en = last_word;
    ureq.hi    = hi;
  end

  pba_word_unit u_unit (
    .word (ram_rdata),
    .req  (ureq),
    .res  (ures)
  );

  assign ram_we    = (state == S_CLR) ||
                     ((state == S_MOD) && ((op != ACT_ALLOC) || ures.found));
  assign ram_wdata = (state == S_CLR) ? {WORD_W{1'b1}} : ures.word_new;

  pba_map_ram #(
    .DEPTH (WORDS),
    .AW    (AW),
    .DW    (WORD_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (widx),
    .wr_data (ram_wdata),
    .rd_addr (widx),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      alloc_limit <= '0;
    end else if (cfg_wr_en) begin
      alloc_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      widx      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          if (widx == LAST_WORD) begin
            state <= S_IDLE;
          end else begin
            widx <= widx + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op         <= action;
            first_iter <= 1'b1;
            res_addr   <= '0;
            res_status <= (action == ACT_ALLOC) && (lim_c == '0);
            case (action) inside
              ACT_FREE, ACT_RESERVE: begin
                if ((range_pages == '0) || (SUM_W'(first) >= PAGES_V)) begin
                  state <= S_FIN;
                end else begin
                  widx  <= AW'(first >> BIT_W);
                  lo    <= first[BIT_W-1:0];
                  wlast <= AW'(last_pg >> BIT_W);
                  hi    <= last_pg[BIT_W-1:0];
                  state <= S_RD;
                end
              end
              ACT_ALLOC: begin
                if (lim_c == '0) begin
                  state <= S_FIN;
                end else begin
                  widx  <= '0;
                  lo    <= '0;
                  wlast <= AW'(lim_m1 >> BIT_W);
                  hi    <= lim_m1[BIT_W-1:0];
                  state <= S_RD;
                end
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_RD: state <= S_MOD;
        S_MOD: begin
          if ((op == ACT_ALLOC) && ures.found) begin
            res_addr <= ADDR_W'(ADDR_W'(found_pg) << PAGE_SHIFT);
            state    <= S_FIN;
          end else if (last_word) begin
            res_status <= (op == ACT_ALLOC);
            state      <= S_FIN;
          end else begin
            widx       <= widx + AW'(1);
            first_iter <= 1'b0;
            state      <= S_RD;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            page_address <= res_addr;
            status       <= res_status;
            state        <= S_IDLE;
          end
        end
        default: state <= S_CLR;
      endcase
    end
  end

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == S_CLR) || (state == S_MOD)))
    else $error("map written outside sweep or modify cycle");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (page_address == '0))
    else $error("out of memory with non-zero address");

  a_no_accept_clr: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !in_ready)
    else $error("transaction accepted during map sweep");

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FIN) && out_valid && !out_ready) |=> (state == S_FIN))
    else $error("result overwrote a waiting transaction");

endmodule
